// ===== rtl/websocket_frame_deframer_unit_macros.svh =====
// Assertion macros for the websocket frame deframer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define WSFD_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// Next-cycle implication check.
`define WSFD_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`else
`define WSFD_ASSERT_IMP(label, clk, rst, pre, post, msg)
`define WSFD_ASSERT_NXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ===== rtl/wsfd_pkg.sv =====
// Shared types for the websocket frame deframer: parser phases, result kinds,
// and the structs passed between the top level and the parser. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsfd_pkg;

   typedef enum logic [2:0] {
      PH_HDR0  = 3'd0,
      PH_HDR1  = 3'd1,
      PH_EXT16 = 3'd2,
      PH_EXT64 = 3'd3,
      PH_KEY   = 3'd4,
      PH_DATA  = 3'd5,
      PH_DONE  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_LAST = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
   localparam logic [2:0] EXT16_LAST_IDX = 3'd1;
   localparam logic [2:0] EXT64_LAST_IDX = 3'd7;
   localparam logic [2:0] KEY_LAST_IDX   = 3'd3;

   // One staged input byte plus its advance strobe and chunk-end flag.
   typedef struct packed {
      logic       en;
      logic [7:0] in_byte;
      logic       chunk_end;
   } byte_in_type;

   // Result produced for the staged byte.
   typedef struct packed {
      logic       valid;
      logic [7:0] out_byte;
      kind_type   kind;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/wsfd_parser.sv =====
// Frame header / payload parser: holds the frame state and computes the result
// for one staged byte per cycle while its advance strobe is high. Depends on wsfd_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_deframer_unit_macros.svh"

module wsfd_parser (
   input  wire                  clock,
   input  wire                  reset,
   input  wsfd_pkg::byte_in_type byte_in,
   output wsfd_pkg::result_type  result
);
   import wsfd_pkg::*;

   phase_type   phase_ff, phase_in, phase_step;
   logic        mask_on_ff, mask_on_in;
   logic [2:0]  header_count_ff, header_count_in;
   logic [63:0] remaining_length_ff, remaining_length_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  mask_index_ff, mask_index_in;

   logic [6:0]  len_code;
   logic [63:0] len_shift;
   logic [2:0]  ext_last_idx;
   logic [7:0]  key_byte;

   // Phase after the length field is complete.
   function automatic phase_type after_len(input logic masked, input logic len_zero);
      phase_type nxt;
      if (masked) begin
         nxt = PH_KEY;
      end else if (len_zero) begin
         nxt = PH_DONE;
      end else begin
         nxt = PH_DATA;
      end
      return nxt;
   endfunction

   assign len_code     = byte_in.in_byte[6:0];
   assign len_shift    = {remaining_length_ff[55:0], byte_in.in_byte};
   assign ext_last_idx = (phase_ff == PH_EXT16) ? EXT16_LAST_IDX : EXT64_LAST_IDX;

   // Next state
   always_comb begin
      phase_step          = phase_ff;
      mask_on_in          = mask_on_ff;
      header_count_in     = header_count_ff;
      remaining_length_in = remaining_length_ff;
      mask_key_in         = mask_key_ff;
      mask_index_in       = mask_index_ff;
      unique case (phase_ff)
         PH_HDR0: begin
            phase_step = PH_HDR1;
         end
         PH_HDR1: begin
            mask_on_in      = byte_in.in_byte[7];
            header_count_in = 3'd0;
            if (len_code == LEN_CODE_EXT16) begin
               remaining_length_in = 64'd0;
               phase_step          = PH_EXT16;
            end else if (len_code == LEN_CODE_EXT64) begin
               remaining_length_in = 64'd0;
               phase_step          = PH_EXT64;
            end else begin
               remaining_length_in = {57'd0, len_code};
               phase_step          = after_len(byte_in.in_byte[7], len_code == 7'd0);
            end
         end
         PH_EXT16, PH_EXT64: begin
            remaining_length_in = len_shift;
            if (header_count_ff == ext_last_idx) begin
               header_count_in = 3'd0;
               phase_step      = after_len(mask_on_ff, len_shift == 64'd0);
            end else begin
               header_count_in = header_count_ff + 3'd1;
            end
         end
         PH_KEY: begin
            mask_key_in = {mask_key_ff[23:0], byte_in.in_byte};
            if (header_count_ff >= KEY_LAST_IDX) begin
               header_count_in = 3'd0;
               mask_index_in   = 2'd0;
               phase_step      = (remaining_length_ff == 64'd0) ? PH_DONE : PH_DATA;
            end else begin
               header_count_in = header_count_ff + 3'd1;
            end
         end
         PH_DATA: begin
            remaining_length_in = remaining_length_ff - 64'd1;
            mask_index_in       = mask_index_ff + 2'd1;
            if (remaining_length_ff == 64'd1) begin
               phase_step = PH_DONE;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase
      phase_in = phase_step;
      // chunk end returns everything to reset values
      if (byte_in.chunk_end) begin
         phase_in            = PH_HDR0;
         mask_on_in          = 1'b0;
         header_count_in     = 3'd0;
         remaining_length_in = 64'd0;
         mask_key_in         = 32'd0;
         mask_index_in       = 2'd0;
      end
   end

   // Outputs
   always_comb begin
      case (mask_index_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
      result.valid    = 1'b0;
      result.out_byte = byte_in.in_byte ^ key_byte;
      result.kind     = (remaining_length_ff == 64'd1) ? KIND_LAST : KIND_DATA;
      if (byte_in.en) begin
         if (byte_in.chunk_end && (phase_step != PH_DONE)) begin
            result.valid    = 1'b1;
            result.out_byte = 8'd0;
            result.kind     = KIND_ERR;
         end else if (phase_ff == PH_DATA) begin
            result.valid = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_HDR0;
         mask_on_ff          <= 1'b0;
         header_count_ff     <= 3'd0;
         remaining_length_ff <= 64'd0;
         mask_key_ff         <= 32'd0;
         mask_index_ff       <= 2'd0;
      end else if (byte_in.en) begin
         phase_ff            <= phase_in;
         mask_on_ff          <= mask_on_in;
         header_count_ff     <= header_count_in;
         remaining_length_ff <= remaining_length_in;
         mask_key_ff         <= mask_key_in;
         mask_index_ff       <= mask_index_in;
      end
   end

   `WSFD_ASSERT_NXT(a_chunk_end_resets, clock, reset, byte_in.en && byte_in.chunk_end,
      phase_ff == PH_HDR0 && mask_key_ff == 32'd0, "parser not reset after chunk end")
   `WSFD_ASSERT_IMP(a_data_len_nonzero, clock, reset, phase_ff == PH_DATA,
      remaining_length_ff != 64'd0, "payload phase with zero length left")
   `WSFD_ASSERT_IMP(a_key_needs_mask, clock, reset, phase_ff == PH_KEY,
      mask_on_ff, "mask key phase on unmasked frame")

endmodule

`default_nettype wire

// ===== rtl/websocket_frame_deframer_unit.sv =====
// Top level of the websocket frame deframer: input stage, parser, result register.
// Depends on wsfd_pkg, wsfd_parser and the assertion macros.
//
// Usage:
//  - req channel: one chunk byte per transfer (req_in_byte), with req_chunk_end
//    high on the last byte of the received chunk.
//  - rsp channel: unmasked payload bytes (rsp_kind data / last payload byte),
//    or one error transfer with rsp_out_byte zero when the chunk ends before
//    the frame header or payload is complete.
//  - Header bytes, mask key bytes, zero-length payloads and bytes after the
//    frame produce no rsp transfer.
//  - Path: an accepted byte is held in the input stage, and its result enters
//    the output register when the staged byte advances to the parser.
//  - Throughput: one byte per cycle while the output is not stalled; the parser
//    is combinational between the input stage and the result register.
//  - Stall: while a result waits in the output register, the staged byte holds
//    and req_ready drops once the input stage is also full.
//  - Reset (synchronous, active high): both stages empty, parser back at the
//    first header byte with length, key and counters cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_deframer_unit_macros.svh"

module websocket_frame_deframer_unit (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire  [7:0] req_in_byte,
   input  wire        req_chunk_end,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind
);
   import wsfd_pkg::*;

   // input stage
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_in_byte_ff;
   logic       s1_chunk_end_ff;
   logic       s1_move;
   logic       req_fire;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_out_byte_ff;
   kind_type   rsp_kind_ff;

   byte_in_type parse_in;
   result_type  parse_res;

   // staged byte advances whenever the result register is free or draining
   assign s1_move     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || s1_move;
   assign req_fire    = req_valid && req_ready;
   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_move);

   assign parse_in.en        = s1_move;
   assign parse_in.in_byte   = s1_in_byte_ff;
   assign parse_in.chunk_end = s1_chunk_end_ff;

   wsfd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .byte_in (parse_in),
      .result  (parse_res)
   );

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || parse_res.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_in_byte_ff   <= req_in_byte;
         s1_chunk_end_ff <= req_chunk_end;
      end
      if (parse_res.valid) begin
         rsp_out_byte_ff <= parse_res.out_byte;
         rsp_kind_ff     <= parse_res.kind;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_kind     = rsp_kind_ff;

   `WSFD_ASSERT_IMP(a_err_byte_zero, clock, reset, rsp_valid_ff && rsp_kind_ff == KIND_ERR,
      rsp_out_byte_ff == 8'd0, "error transfer carries nonzero byte")
   `WSFD_ASSERT_NXT(a_stage_holds, clock, reset, s1_valid_ff && !s1_move,
      s1_valid_ff && $stable(s1_in_byte_ff) && $stable(s1_chunk_end_ff),
      "staged byte lost or changed while stalled")
   `WSFD_ASSERT_IMP(a_no_overwrite, clock, reset, parse_res.valid,
      !rsp_valid_ff || rsp_ready, "result register overwritten while full")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for websocket_frame_deframer_unit: drives frame chunks
// byte by byte and checks every response against a cycle-free frame parser.
// Depends on wsfd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb_top;

   import wsfd_pkg::*;

   typedef struct {
      logic [7:0] out_byte;
      kind_type   kind;
   } deframe_result_type;

   // Tracks the frame parse of accepted bytes and holds the responses they owe.
   class deframe_scoreboard;
      phase_type           cur_phase;
      logic                masked;
      logic [2:0]          hdr_idx;
      logic [63:0]         bytes_left;
      logic [31:0]         key_word;
      logic [1:0]          key_pos;
      deframe_result_type  owed[$];
      int                  errors;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         cur_phase  = PH_HDR0;
         masked     = 1'b0;
         hdr_idx    = '0;
         bytes_left = '0;
         key_word   = '0;
         key_pos    = '0;
      endfunction

      function void after_length();
         hdr_idx = '0;
         if (masked)
            cur_phase = PH_KEY;
         else if (bytes_left == 0)
            cur_phase = PH_DONE;
         else
            cur_phase = PH_DATA;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // One accepted request transfer.
      function void note_byte(logic [7:0] b, logic last);
         deframe_result_type r;
         logic               got;
         logic [6:0]         code;
         logic [2:0]         len_last;
         int                 kp;
         got        = 1'b0;
         r.out_byte = '0;
         r.kind     = KIND_DATA;
         case (cur_phase)
            PH_HDR0: cur_phase = PH_HDR1;
            PH_HDR1: begin
               masked  = b[7];
               code    = b[6:0];
               hdr_idx = '0;
               if (code == LEN_CODE_EXT16) begin
                  bytes_left = '0;
                  cur_phase  = PH_EXT16;
               end else if (code == LEN_CODE_EXT64) begin
                  bytes_left = '0;
                  cur_phase  = PH_EXT64;
               end else begin
                  bytes_left = 64'(code);
                  after_length();
               end
            end
            PH_EXT16, PH_EXT64: begin
               bytes_left = {bytes_left[55:0], b};
               len_last = (cur_phase == PH_EXT16) ? EXT16_LAST_IDX : EXT64_LAST_IDX;
               if (hdr_idx == len_last)
                  after_length();
               else
                  hdr_idx = hdr_idx + 3'd1;
            end
            PH_KEY: begin
               key_word = {key_word[23:0], b};
               if (hdr_idx >= KEY_LAST_IDX) begin
                  hdr_idx   = '0;
                  key_pos   = '0;
                  cur_phase = (bytes_left == 0) ? PH_DONE : PH_DATA;
               end else begin
                  hdr_idx = hdr_idx + 3'd1;
               end
            end
            PH_DATA: begin
               kp         = key_pos;
               r.out_byte = b ^ key_word[8 * (3 - kp) +: 8];
               bytes_left = bytes_left - 64'd1;
               key_pos    = key_pos + 2'd1;
               if (bytes_left == 0) begin
                  r.kind    = KIND_LAST;
                  cur_phase = PH_DONE;
               end
               got = 1'b1;
            end
            default: ;
         endcase
         if (last) begin
            // chunk ended with the frame still open: error replaces any data byte
            if (cur_phase != PH_DONE && cur_phase <= PH_DATA) begin
               r.out_byte = '0;
               r.kind     = KIND_ERR;
               got        = 1'b1;
            end
            clear();
         end
         if (got)
            owed = {owed, r};
      endfunction

      // One accepted response transfer.
      function void check_result(logic [7:0] out_byte, logic [1:0] kind);
         deframe_result_type r;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response: out_byte %h kind %0d", out_byte, kind);
            return;
         end
         r = owed.pop_front();
         if (out_byte !== r.out_byte || kind !== r.kind) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected out_byte %h kind %0d, got out_byte %h kind %0d",
                        r.out_byte, r.kind, out_byte, kind);
         end
      endfunction
   endclass

   localparam int BYTE_TARGET = 850;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic [7:0] req_in_byte   = 8'h00;
   logic       req_chunk_end = 1'b0;
   logic       rsp_ready     = 1'b0;
   wire        req_ready;
   wire        rsp_valid;
   wire  [7:0] rsp_out_byte;
   wire  [1:0] rsp_kind;

   deframe_scoreboard sb;
   logic [7:0]        chunk_bytes[$];
   int                burst_left = 0;
   int                sent_count = 0;
   int                hold_left  = 0;
   int                holds_done = 0;
   logic [31:0]       rx_cycle   = '0;

   websocket_frame_deframer_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_chunk_end (req_chunk_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_kind      (rsp_kind)
   );

   always #5 clock = ~clock;

   // appends one byte to the chunk under construction
   function automatic void append_byte(input logic [7:0] b);
      chunk_bytes = {chunk_bytes, b};
   endfunction

   // Sender: bursts of random length, short random gaps between them.
   // Inputs change only by NBA at a rising edge; the transfer is seen on the
   // edge where the pre-edge valid and ready are both high.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         // about one burst in four is long, so back-to-back traffic shows up too
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 24);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= b;
      req_chunk_end <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(b, last);
      sent_count++;
      burst_left--;
   endtask

   // chunk_end rides on the final byte of the chunk
   task automatic send_chunk();
      int i;
      for (i = 0; i < chunk_bytes.size(); i++)
         send_byte(chunk_bytes[i], i == chunk_bytes.size() - 1);
   endtask

   // Builds one random chunk: mostly well-formed frames with random content,
   // some cut short, some with trailing bytes, and some plain noise.
   task automatic build_chunk();
      int          sel;
      int          lsel;
      int          i;
      int          n;
      int          body;
      logic        mask_bit;
      logic        huge;
      logic        cut;
      logic [6:0]  code;
      logic [63:0] len;
      chunk_bytes.delete();
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         n = $urandom_range(1, 12);
         for (i = 0; i < n; i++)
            append_byte(8'($urandom));
         return;
      end
      mask_bit = 1'($urandom_range(0, 1));
      lsel     = $urandom_range(0, 9);
      huge     = 1'b0;
      append_byte(8'($urandom));   // FIN / opcode, don't care
      if (lsel <= 5) begin
         len  = ($urandom_range(0, 5) == 0) ? 64'($urandom_range(0, 125))
                                            : 64'($urandom_range(0, 20));
         code = len[6:0];
         append_byte({mask_bit, code});
      end else if (lsel <= 7) begin
         len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(126, 300))
                                           : 64'($urandom_range(0, 24));
         append_byte({mask_bit, LEN_CODE_EXT16});
         append_byte(len[15:8]);
         append_byte(len[7:0]);
      end else begin
         // 64-bit length: now and then a full random value that can't finish
         huge = ($urandom_range(0, 3) == 0);
         len  = huge ? {$urandom, $urandom} : 64'($urandom_range(0, 24));
         append_byte({mask_bit, LEN_CODE_EXT64});
         for (i = 0; i < 8; i++)
            append_byte(len[63 - 8 * i -: 8]);
      end
      if (mask_bit)
         for (i = 0; i < 4; i++)
            append_byte(8'($urandom));
      body = huge ? $urandom_range(0, 5) : int'(len);
      for (i = 0; i < body; i++)
         append_byte(8'($urandom));
      cut = huge || ($urandom_range(0, 99) < 15);
      if (cut) begin
         n = huge ? $urandom_range(1, chunk_bytes.size())
                  : $urandom_range(1, chunk_bytes.size() - 1);
         while (chunk_bytes.size() > n) chunk_bytes.pop_back();
      end else if ($urandom_range(0, 9) < 3) begin
         n = $urandom_range(1, 3);
         for (i = 0; i < n; i++)
            append_byte(8'($urandom));
      end
   endtask

   // Receiver: stall pattern of its own, chosen by rx_cycle[7:6], plus two
   // long hold-offs while the sender keeps offering bytes, so both stages fill
   // and req_ready drops.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_out_byte, rsp_kind);
      rx_cycle <= rx_cycle + 32'd1;
      if (hold_left == 0 && holds_done < 2 && sent_count >= 300 * (holds_done + 1)) begin
         hold_left = 200;
         holds_done++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_cycle[7:6])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= 1'($urandom_range(0, 1));
            2'd2: rsp_ready <= (rx_cycle[1:0] == 2'd0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2ms;
      $display("simulation failed");
      $finish;
   end

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed chunks.
      // unmasked zero-length frame: nothing comes back
      chunk_bytes = '{8'h81, 8'h00};
      send_chunk();
      // masked zero-length frame, chunk ends on the last key byte
      chunk_bytes = '{8'h82, 8'h80, 8'h11, 8'h22, 8'h33, 8'h44};
      send_chunk();
      // masked one-byte payload, all-ones key, zero data byte
      chunk_bytes = '{8'h00, 8'h81, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
      send_chunk();
      // chunk ends on the first header byte: truncation error
      chunk_bytes = '{8'hFF};
      send_chunk();
      // 16-bit length of two, then one trailing byte that must be ignored
      chunk_bytes = '{8'h82, 8'h7E, 8'h00, 8'h02, 8'h12, 8'h34, 8'hAA};
      send_chunk();
      // masked 64-bit length cut off in its first length byte
      chunk_bytes = '{8'h82, 8'hFF, 8'h80};
      send_chunk();

      // Random chunks.
      while (sent_count < BYTE_TARGET) begin
         build_chunk();
         send_chunk();
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
